// ===== sv/fam_pkg.sv =====
// Shared widths, op codes and pipeline payload types for the fraction reducer.
package fam_pkg;

  localparam int unsigned OperandBitsDefault = 16;
  localparam int unsigned FieldW = 16;
  localparam int unsigned ValW   = 33;           // numerator width, holds denominator too
  localparam int unsigned DenW   = 32;
  localparam int unsigned ShW    = 6;
  localparam int unsigned GcdSteps = 2 * (ValW + DenW) + 2;

  typedef enum logic [1:0] {
    OP_MUL    = 2'd0,
    OP_ADD    = 2'd1,
    OP_REDUCE = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [ValW-1:0] num;
    logic [ValW-1:0] den;
    logic [ValW-1:0] x;
    logic [ValW-1:0] y;
    logic [ShW-1:0]  sh;
    logic            err;
  } gcd_t;

  typedef struct packed {
    logic [ValW-1:0] num;
    logic [ValW-1:0] den;
    logic [ValW-1:0] g;
    logic [ValW-1:0] num_q;
    logic [ValW-1:0] den_q;
    logic [ValW:0]   num_rem;
    logic [ValW:0]   den_rem;
    logic            err;
  } div_t;

endpackage

// ===== sv/fam_front.sv =====
// Operand masking, cross products and selection of the unreduced fraction.
module fam_front #(
  parameter int unsigned OPERAND_BITS = fam_pkg::OperandBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  fam_pkg::op_e               op_i,
  input  logic [fam_pkg::FieldW-1:0] a_num_i,
  input  logic [fam_pkg::FieldW-1:0] a_den_i,
  input  logic [fam_pkg::FieldW-1:0] b_num_i,
  input  logic [fam_pkg::FieldW-1:0] b_den_i,
  output logic                       valid_o,
  output fam_pkg::gcd_t              data_o
);

  localparam logic [fam_pkg::FieldW-1:0] OpMask = (OPERAND_BITS >= fam_pkg::FieldW) ?
      {fam_pkg::FieldW{1'b1}} :
      fam_pkg::FieldW'((17'd1 << OPERAND_BITS) - 17'd1);

  logic [fam_pkg::FieldW-1:0] an, ad, bn, bd;
  logic                       uses_b;
  logic                       v1_q;
  fam_pkg::op_e               op1_q;
  logic                       err1_q;
  logic [fam_pkg::FieldW-1:0] an1_q, ad1_q;
  logic [fam_pkg::DenW-1:0]   p_nn_q, p_dd_q, p_nd_q, p_dn_q;
  logic [fam_pkg::ValW-1:0]   num_sel;
  logic [fam_pkg::ValW-1:0]   den_sel;
  fam_pkg::gcd_t              data_d, data_q;
  logic                       valid_q;

  assign an = a_num_i & OpMask;
  assign ad = a_den_i & OpMask;
  assign bn = b_num_i & OpMask;
  assign bd = b_den_i & OpMask;
  assign uses_b = (op_i == fam_pkg::OP_MUL) || (op_i == fam_pkg::OP_ADD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q  <= op_i;
      err1_q <= (ad == '0) || (uses_b && (bd == '0));
      an1_q  <= an;
      ad1_q  <= ad;
      p_nn_q <= fam_pkg::DenW'(an) * fam_pkg::DenW'(bn);
      p_dd_q <= fam_pkg::DenW'(ad) * fam_pkg::DenW'(bd);
      p_nd_q <= fam_pkg::DenW'(an) * fam_pkg::DenW'(bd);
      p_dn_q <= fam_pkg::DenW'(ad) * fam_pkg::DenW'(bn);
      data_q <= data_d;
    end
  end

  always_comb begin
    unique case (op1_q)
      fam_pkg::OP_MUL: begin
        num_sel = fam_pkg::ValW'(p_nn_q);
        den_sel = fam_pkg::ValW'(p_dd_q);
      end
      fam_pkg::OP_ADD: begin
        num_sel = fam_pkg::ValW'(p_nd_q) + fam_pkg::ValW'(p_dn_q);
        den_sel = fam_pkg::ValW'(p_dd_q);
      end
      default: begin
        num_sel = fam_pkg::ValW'(an1_q);
        den_sel = fam_pkg::ValW'(ad1_q);
      end
    endcase
  end

  // Error and zero numerator leave the gcd finished at one.
  always_comb begin
    data_d.err = err1_q;
    data_d.sh  = '0;
    if (err1_q) begin
      data_d.num = '0;
      data_d.den = '0;
      data_d.x   = fam_pkg::ValW'(1);
      data_d.y   = '0;
    end else if (num_sel == '0) begin
      data_d.num = '0;
      data_d.den = fam_pkg::ValW'(1);
      data_d.x   = fam_pkg::ValW'(1);
      data_d.y   = '0;
    end else begin
      data_d.num = num_sel;
      data_d.den = den_sel;
      data_d.x   = num_sel;
      data_d.y   = den_sel;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/fam_gcd_step.sv =====
// One registered step of the binary gcd.
module fam_gcd_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  fam_pkg::gcd_t data_i,
  output logic          valid_o,
  output fam_pkg::gcd_t data_o
);

  fam_pkg::gcd_t data_d, data_q;
  logic          valid_q;

  always_comb begin
    data_d = data_i;
    if (data_i.y != '0) begin
      priority if (!data_i.x[0] && !data_i.y[0]) begin
        data_d.x  = data_i.x >> 1;
        data_d.y  = data_i.y >> 1;
        data_d.sh = data_i.sh + fam_pkg::ShW'(1);
      end else if (!data_i.x[0]) begin
        data_d.x = data_i.x >> 1;
      end else if (!data_i.y[0]) begin
        data_d.y = data_i.y >> 1;
      end else if (data_i.x > data_i.y) begin
        data_d.x = data_i.y;
        data_d.y = data_i.x - data_i.y;
      end else begin
        data_d.y = data_i.y - data_i.x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/fam_div_step.sv =====
// One registered quotient bit of both exact divisions by the gcd.
module fam_div_step #(
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  fam_pkg::div_t data_i,
  output logic          valid_o,
  output fam_pkg::div_t data_o
);

  fam_pkg::div_t           data_d, data_q;
  logic                    valid_q;
  logic [fam_pkg::ValW:0]  nr, dr, gx;

  always_comb begin
    data_d = data_i;
    gx = {1'b0, data_i.g};
    nr = {data_i.num_rem[fam_pkg::ValW-1:0], data_i.num[BIT]};
    dr = {data_i.den_rem[fam_pkg::ValW-1:0], data_i.den[BIT]};
    if (nr >= gx) begin
      nr = nr - gx;
      data_d.num_q[BIT] = 1'b1;
    end else begin
      data_d.num_q[BIT] = 1'b0;
    end
    if (dr >= gx) begin
      dr = dr - gx;
      data_d.den_q[BIT] = 1'b1;
    end else begin
      data_d.den_q[BIT] = 1'b0;
    end
    data_d.num_rem = nr;
    data_d.den_rem = dr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/fraction_add_multiply_reduce_top.sv =====
// Top level of the pipelined fraction multiply, add and reduce block.
// Usage:
//   Slave channel carries one transaction per fraction pair: tdata holds
//   a_num, a_den, b_num, b_den (16 bits each, a_num lowest) and tuser holds
//   the op (0 multiply, 1 add, 2 or 3 reduce the first fraction alone).
//   Master channel returns one transaction per input: tdata holds res_num
//   (33 bits) then res_den (32 bits), zero-padded to 72 bits; tuser holds
//   div_by_zero. On a zero denominator in use the result is 0 over 0 with
//   the flag set; a zero numerator gives 0 over 1.
// Timing:
//   The front registers the cross products, then the selected fraction; 132
//   single-step binary gcd stages follow, then 33 stages produce one
//   quotient bit each for numerator and denominator.
//   One transaction may enter in every cycle unless the output stalls, so
//   the sustained rate is one item per cycle; the gcd chain length sets the latency.
// Reset clears every stage valid bit, so the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
module fraction_add_multiply_reduce_top #(
  parameter int unsigned OPERAND_BITS = fam_pkg::OperandBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // a_num[15:0], a_den[31:16], b_num[47:32], b_den[63:48]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // res_num[32:0], res_den[64:33], zero pad
  output logic        m_axis_tuser    // div_by_zero
);

  localparam int unsigned Steps = fam_pkg::GcdSteps;
  localparam int unsigned W     = fam_pkg::ValW;

  logic          adv;
  logic          gv [Steps+1];
  fam_pkg::gcd_t gd [Steps+1];
  logic          dv [W+1];
  fam_pkg::div_t dd [W+1];
  fam_pkg::gcd_t gl;

  // Advance everything unless the output register holds an untaken result.
  assign adv           = !dv[W] || m_axis_tready;
  assign s_axis_tready = adv;

  fam_front #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .op_i    (fam_pkg::op_e'(s_axis_tuser)),
    .a_num_i (s_axis_tdata[15:0]),
    .a_den_i (s_axis_tdata[31:16]),
    .b_num_i (s_axis_tdata[47:32]),
    .b_den_i (s_axis_tdata[63:48]),
    .valid_o (gv[0]),
    .data_o  (gd[0])
  );

  for (genvar i = 0; i < Steps; i++) begin : g_gcd
    fam_gcd_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (gv[i]),
      .data_i  (gd[i]),
      .valid_o (gv[i+1]),
      .data_o  (gd[i+1])
    );
  end

  // Restore the common power of two and start the divisions.
  assign gl    = gd[Steps];
  assign dd[0] = '{num:     gl.num,
                   den:     gl.den,
                   g:       gl.x << gl.sh,
                   num_q:   '0,
                   den_q:   '0,
                   num_rem: '0,
                   den_rem: '0,
                   err:     gl.err};
  assign dv[0] = gv[Steps];

  for (genvar k = 0; k < W; k++) begin : g_div
    fam_div_step #(
      .BIT(W - 1 - k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv[k]),
      .data_i  (dd[k]),
      .valid_o (dv[k+1]),
      .data_o  (dd[k+1])
    );
  end

  assign m_axis_tvalid = dv[W];
  assign m_axis_tdata  = {7'd0, dd[W].den_q[fam_pkg::DenW-1:0], dd[W].num_q};
  assign m_axis_tuser  = dd[W].err;

endmodule

// ===== tb/tb_fraction_add_multiply_reduce_top.sv =====
// Self-checking testbench for the fraction multiply, add and reduce block.
module tb_fraction_add_multiply_reduce_top;

  localparam int unsigned Latency  = 167;
  localparam int unsigned WatchMax = 20000;

  typedef struct packed {
    logic [32:0] num;
    logic [31:0] den;
    logic        dz;
  } frac_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // a_num, a_den, b_num, b_den from the lowest bit up
  logic [1:0]  s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // res_num, res_den, zero pad
  logic        m_axis_tuser;   // div_by_zero

  frac_res_t   expected_q[$];
  int unsigned n_errors;
  int unsigned idle_cycles;
  bit          hold_off;
  bit          burst_on;

  fraction_add_multiply_reduce_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Euclid on 64-bit values; both arguments nonzero.
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_fraction(fam_pkg::op_e op, logic [15:0] an,
                                                logic [15:0] ad, logic [15:0] bn,
                                                logic [15:0] bd);
    frac_res_t   r;
    logic [63:0] num, den, g;
    bit          uses_b;
    uses_b = (op == fam_pkg::OP_MUL) || (op == fam_pkg::OP_ADD);
    r = '0;
    if (ad == 0 || (uses_b && bd == 0)) begin
      r.dz = 1'b1;
      return r;
    end
    case (op)
      fam_pkg::OP_MUL: begin
        num = 64'(an) * 64'(bn);
        den = 64'(ad) * 64'(bd);
      end
      fam_pkg::OP_ADD: begin
        num = 64'(an) * 64'(bd) + 64'(ad) * 64'(bn);
        den = 64'(ad) * 64'(bd);
      end
      default: begin
        num = 64'(an);
        den = 64'(ad);
      end
    endcase
    if (num == 0) begin
      r.den = 32'd1;
      return r;
    end
    g = gcd64(num, den);
    r.num = 33'(num / g);
    r.den = 32'(den / g);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // Offer one transaction and hold it until the block takes it.
  task automatic send_fraction(fam_pkg::op_e op, logic [15:0] an, logic [15:0] ad,
                               logic [15:0] bn, logic [15:0] bd);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bd, bn, ad, an};
    s_axis_tuser  <= op;
    expected_q.push_back(reduce_fraction(op, an, ad, bn, bd));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Bursts of random length, then a random gap with tvalid low.
  task automatic pace_sender();
    int unsigned gap;
    if (!burst_on || $urandom_range(0, 7) == 0) begin
      burst_on = $urandom_range(0, 3) != 0;
      if (!burst_on) begin
        gap = $urandom_range(1, 6);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
        burst_on = 1'b1;
      end
    end
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 12));
      3:       return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_fraction(fam_pkg::OP_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fraction(fam_pkg::OP_ADD, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
    send_fraction(fam_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    send_fraction(fam_pkg::OP_MUL, 16'd6, 16'd8, 16'd4, 16'd9);
    send_fraction(fam_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_fraction(fam_pkg::OP_REDUCE, 16'd12, 16'd18, 16'hFFFF, 16'd0);
    send_fraction(fam_pkg::OP_SPARE, 16'd100, 16'd75, 16'd3, 16'd0);
    // zero denominators in use
    send_fraction(fam_pkg::OP_MUL, 16'd3, 16'd0, 16'd1, 16'd1);
    send_fraction(fam_pkg::OP_ADD, 16'd3, 16'd5, 16'd1, 16'd0);
    send_fraction(fam_pkg::OP_REDUCE, 16'd7, 16'd0, 16'd1, 16'd1);
    // zero numerators
    send_fraction(fam_pkg::OP_MUL, 16'd0, 16'd5, 16'd9, 16'd3);
    send_fraction(fam_pkg::OP_ADD, 16'd0, 16'd5, 16'd0, 16'd3);
    send_fraction(fam_pkg::OP_REDUCE, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_fraction(fam_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h4000);
    send_fraction(fam_pkg::OP_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    send_fraction(fam_pkg::OP_REDUCE, 16'hFFFF, 16'h0001, 16'd0, 16'd0);
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) begin
      pace_sender();
      send_fraction(fam_pkg::op_e'($urandom_range(0, 3)), rand_field(), rand_field(),
                    rand_field(), rand_field());
    end
  endtask

  // Stall the receiver for a long stretch while items keep coming in.
  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (300) begin
      send_fraction(fam_pkg::op_e'($urandom_range(0, 3)), rand_field(), rand_field(),
                    rand_field(), rand_field());
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 20) @(negedge clk_i);
  endtask

  // Receiver stall pattern, plus the long hold-off counted here.
  initial begin
    int unsigned held;
    m_axis_tready = 1'b0;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off && held < 600) begin
        m_axis_tready <= 1'b0;
        held++;
      end else begin
        hold_off = 1'b0;
        held     = 0;
        m_axis_tready <= ($urandom_range(0, 63) < 40) ? 1'b1 : ($urandom_range(0, 1) == 1);
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    frac_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(m_axis_tdata[32:0]), 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[32:0] !== want.num)
          report_mismatch("res_num", 64'(m_axis_tdata[32:0]), 64'(want.num));
        if (m_axis_tdata[64:33] !== want.den)
          report_mismatch("res_den", 64'(m_axis_tdata[64:33]), 64'(want.den));
        if (m_axis_tuser !== want.dz)
          report_mismatch("div_by_zero", 64'(m_axis_tuser), 64'(want.dz));
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchMax) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    n_errors      = 0;
    idle_cycles   = 0;
    hold_off      = 1'b0;
    burst_on      = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(520);
    test_backpressure();
    drain();
    if (expected_q.size() != 0) begin
      $display("%0d results never arrived", expected_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== fraction_add_multiply_reduce_top.f =====
sv/fam_pkg.sv
sv/fam_front.sv
sv/fam_gcd_step.sv
sv/fam_div_step.sv
sv/fraction_add_multiply_reduce_top.sv
tb/tb_fraction_add_multiply_reduce_top.sv
